/* hw/rtl/assert_macros.svh */
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expr holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

// ante implies cons in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// ante implies cons in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* hw/rtl/rau_pkg.sv */
`timescale 1ns / 1ps

package rau_pkg;

	localparam int OPERAND_WIDTH = 16;
	localparam int OPR_W = OPERAND_WIDTH + 1;  // reduced operand, -MIN/-1 needs one more bit
	localparam int MAG_W = 2 * OPERAND_WIDTH;  // magnitude of any intermediate value
	localparam int NUM_W = MAG_W + 1;
	localparam int DEN_W = MAG_W;
	localparam int CNT_W = $clog2(MAG_W + 1);

	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_SUB = 2'd1;
	localparam logic [1:0] MODE_MUL = 2'd2;
	localparam logic [1:0] MODE_DIV = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_EU_CHK,
		ST_EU_WAIT,
		ST_DN_WAIT,
		ST_DD_WAIT,
		ST_STORE,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_COMB,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_A,
		PH_B,
		PH_R
	} phase_t;

	typedef enum logic [1:0] {
		DS_REM,
		DS_NUM,
		DS_DEN
	} div_sel_t;

	typedef enum logic [1:0] {
		MS_P1,
		MS_P2,
		MS_P3
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     ld_pair;
		logic     pair_b;
		logic     div_start;
		div_sel_t div_sel;
		logic     div_short;
		logic     eu_step;
		logic     n_upd;
		logic     d_upd;
		logic     store_a;
		logic     store_b;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     combine;
		logic     out_write;
	} cmd_t;

	typedef struct packed {
		logic y_zero;
		logic div_done;
		logic out_busy;
	} stat_t;

endpackage

/* hw/rtl/rau_div.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rau_div import rau_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    short_op,
	input  logic signed [NUM_W-1:0] dividend,
	input  logic signed [NUM_W-1:0] divisor,
	output logic                    done,
	output logic signed [NUM_W-1:0] quo,
	output logic signed [NUM_W-1:0] rem
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MAG_W-1:0] rem_q;
	logic [MAG_W-1:0] quo_q;
	logic [MAG_W-1:0] dvs_q;
	logic             sq_q;
	logic             sr_q;

	logic [NUM_W-1:0] dvd_abs;
	logic [NUM_W-1:0] dvs_abs;
	logic [MAG_W:0]   shifted;
	logic [MAG_W:0]   trial;
	logic signed [NUM_W-1:0] qext;
	logic signed [NUM_W-1:0] rext;

	assign dvd_abs = dividend[NUM_W-1] ? -dividend : dividend;
	assign dvs_abs = divisor[NUM_W-1] ? -divisor : divisor;
	assign shifted = {rem_q, quo_q[MAG_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= short_op ? CNT_W'(OPERAND_WIDTH) : CNT_W'(MAG_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring divide on magnitudes, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			// short words fit the low half; left-align them to skip zero bits
			quo_q <= short_op ? (dvd_abs[MAG_W-1:0] << OPERAND_WIDTH) : dvd_abs[MAG_W-1:0];
			dvs_q <= dvs_abs[MAG_W-1:0];
			sq_q  <= dividend[NUM_W-1] ^ divisor[NUM_W-1];
			sr_q  <= dividend[NUM_W-1];
		end else if (busy_q) begin
			if (!trial[MAG_W]) begin
				rem_q <= trial[MAG_W-1:0];
				quo_q <= {quo_q[MAG_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[MAG_W-1:0];
				quo_q <= {quo_q[MAG_W-2:0], 1'b0};
			end
		end
	end

	// truncating semantics: quotient sign is the xor, remainder follows the dividend
	assign qext = {1'b0, quo_q};
	assign rext = {1'b0, rem_q};
	assign quo  = sq_q ? -qext : qext;
	assign rem  = sr_q ? -rext : rext;
	assign done = done_q;

	`ASSERT_ALWAYS(a_no_restart, clk, arst_n, !(start && busy_q))
	`ASSERT_IMPL(a_nonzero_divisor, clk, arst_n, start, divisor != '0)
	`ASSERT_NEXT(a_start_busy, clk, arst_n, start, busy_q)
	`ASSERT_IMPL(a_done_after_busy, clk, arst_n, done_q, $past(busy_q) && !busy_q)

endmodule

/* hw/rtl/rau_dp.sv */
`timescale 1ns / 1ps

module rau_dp import rau_pkg::*; (
	input  logic                            clk,
	input  logic                            arst_n,
	input  cmd_t                            cmd,
	output stat_t                           stat,
	input  logic [1:0]                      mode,
	input  logic signed [OPERAND_WIDTH-1:0] a_num,
	input  logic signed [OPERAND_WIDTH-1:0] a_den,
	input  logic signed [OPERAND_WIDTH-1:0] b_num,
	input  logic signed [OPERAND_WIDTH-1:0] b_den,
	input  logic                            out_stall,
	output logic                            out_valid,
	output logic signed [NUM_W-1:0]         res_num,
	output logic signed [DEN_W-1:0]         res_den,
	output logic                            div_zero,
	output logic                            den_fixed
);

	localparam logic signed [OPR_W-1:0] OPR_ONE = {{(OPR_W-1){1'b0}}, 1'b1};
	localparam logic signed [NUM_W-1:0] NUM_ONE = {{(NUM_W-1){1'b0}}, 1'b1};

	logic [1:0]              mode_q;
	logic                    fix_q;
	logic                    dz_q;
	logic signed [OPR_W-1:0] an_q, ad_q, bn_q, bd_q;
	logic signed [NUM_W-1:0] n_q, d_q, x_q, y_q;
	logic signed [MAG_W-1:0] p1_q, p2_q, p3_q;

	logic                    out_valid_q;
	logic signed [NUM_W-1:0] res_num_q;
	logic signed [DEN_W-1:0] res_den_q;
	logic                    div_zero_q;
	logic                    den_fixed_q;

	logic signed [OPR_W-1:0]   src_n, src_d;
	logic signed [NUM_W-1:0]   src_n_x, src_d_x;
	logic signed [NUM_W-1:0]   dvd, dvs;
	logic signed [NUM_W-1:0]   div_quo, div_rem;
	logic                      div_done;
	logic signed [OPR_W-1:0]   ma, mb;
	logic signed [2*OPR_W-1:0] prod;
	logic signed [NUM_W-1:0]   p1_x, p2_x, p3_x;
	logic signed [NUM_W-1:0]   nv, dv, dv_raw;
	logic                      b_zero;

	assign src_n   = cmd.pair_b ? bn_q : an_q;
	assign src_d   = cmd.pair_b ? bd_q : ad_q;
	assign src_n_x = {{(NUM_W-OPR_W){src_n[OPR_W-1]}}, src_n};
	assign src_d_x = {{(NUM_W-OPR_W){src_d[OPR_W-1]}}, src_d};

	always_comb begin
		case (cmd.div_sel)
			DS_REM: begin
				dvd = x_q;
				dvs = y_q;
			end
			DS_NUM: begin
				dvd = n_q;
				dvs = x_q;
			end
			DS_DEN: begin
				dvd = d_q;
				dvs = x_q;
			end
			default: begin
				dvd = x_q;
				dvs = y_q;
			end
		endcase
	end

	rau_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.short_op (cmd.div_short),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (div_done),
		.quo      (div_quo),
		.rem      (div_rem)
	);

	always_comb begin
		case (cmd.mul_sel)
			MS_P1: begin
				ma = an_q;
				mb = (mode_q == MODE_MUL) ? bn_q : bd_q;
			end
			MS_P2: begin
				ma = bn_q;
				mb = ad_q;
			end
			MS_P3: begin
				ma = ad_q;
				mb = (mode_q == MODE_DIV) ? bn_q : bd_q;
			end
			default: begin
				ma = an_q;
				mb = bd_q;
			end
		endcase
	end

	assign prod = ma * mb;

	assign p1_x   = {p1_q[MAG_W-1], p1_q};
	assign p2_x   = {p2_q[MAG_W-1], p2_q};
	assign p3_x   = {p3_q[MAG_W-1], p3_q};
	assign b_zero = (bn_q == '0);

	always_comb begin
		dv_raw = p3_x;
		case (mode_q)
			MODE_ADD: nv = p1_x + p2_x;
			MODE_SUB: nv = p1_x - p2_x;
			MODE_MUL: nv = p1_x;
			MODE_DIV: begin
				if (b_zero) begin
					nv     = {{(NUM_W-OPR_W){an_q[OPR_W-1]}}, an_q};
					dv_raw = {{(NUM_W-OPR_W){ad_q[OPR_W-1]}}, ad_q};
				end else begin
					nv = p1_x;
				end
			end
			default: nv = p1_x;
		endcase
		dv = (dv_raw == '0) ? NUM_ONE : dv_raw;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			fix_q  <= (a_den == '0) || (b_den == '0);
			an_q   <= {a_num[OPERAND_WIDTH-1], a_num};
			ad_q   <= (a_den == '0) ? OPR_ONE : {a_den[OPERAND_WIDTH-1], a_den};
			bn_q   <= {b_num[OPERAND_WIDTH-1], b_num};
			bd_q   <= (b_den == '0) ? OPR_ONE : {b_den[OPERAND_WIDTH-1], b_den};
		end else begin
			if (cmd.store_a) begin
				an_q <= n_q[OPR_W-1:0];
				ad_q <= d_q[OPR_W-1:0];
			end
			if (cmd.store_b) begin
				bn_q <= n_q[OPR_W-1:0];
				bd_q <= d_q[OPR_W-1:0];
			end
		end

		if (cmd.ld_pair) begin
			n_q <= src_n_x;
			d_q <= src_d_x;
			x_q <= src_n_x;
			y_q <= src_d_x;
		end else if (cmd.combine) begin
			n_q  <= nv;
			d_q  <= dv;
			x_q  <= nv;
			y_q  <= dv;
			dz_q <= (mode_q == MODE_DIV) && b_zero;
		end else begin
			if (cmd.eu_step) begin
				x_q <= y_q;
				y_q <= div_rem;
			end
			if (cmd.n_upd)
				n_q <= div_quo;
			if (cmd.d_upd)
				d_q <= div_quo;
		end

		if (cmd.mul_en) begin
			case (cmd.mul_sel)
				MS_P1: p1_q <= prod[MAG_W-1:0];
				MS_P2: p2_q <= prod[MAG_W-1:0];
				MS_P3: p3_q <= prod[MAG_W-1:0];
				default: p1_q <= prod[MAG_W-1:0];
			endcase
		end

		if (cmd.out_write) begin
			res_num_q   <= n_q;
			res_den_q   <= d_q[DEN_W-1:0];
			div_zero_q  <= dz_q;
			den_fixed_q <= fix_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_write) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.y_zero   = (y_q == '0);
	assign stat.div_done = div_done;
	assign stat.out_busy = out_valid_q && out_stall;

	assign out_valid = out_valid_q;
	assign res_num   = res_num_q;
	assign res_den   = res_den_q;
	assign div_zero  = div_zero_q;
	assign den_fixed = den_fixed_q;

endmodule

/* hw/rtl/rau_ctrl.sv */
`timescale 1ns / 1ps

module rau_ctrl import rau_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q, state_d;
	phase_t phase_q, phase_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_A;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d       = state_q;
		phase_d       = phase_q;
		cmd           = '0;
		cmd.pair_b    = (phase_q == PH_B);
		cmd.div_short = (phase_q != PH_R);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					phase_d  = PH_A;
					state_d  = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.ld_pair = 1'b1;
				state_d     = ST_EU_CHK;
			end
			ST_EU_CHK: begin
				cmd.div_start = 1'b1;
				if (stat.y_zero) begin
					// x holds the divisor; reduce the numerator first
					cmd.div_sel = DS_NUM;
					state_d     = ST_DN_WAIT;
				end else begin
					cmd.div_sel = DS_REM;
					state_d     = ST_EU_WAIT;
				end
			end
			ST_EU_WAIT: begin
				if (stat.div_done) begin
					cmd.eu_step = 1'b1;
					state_d     = ST_EU_CHK;
				end
			end
			ST_DN_WAIT: begin
				if (stat.div_done) begin
					cmd.n_upd     = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel   = DS_DEN;
					state_d       = ST_DD_WAIT;
				end
			end
			ST_DD_WAIT: begin
				if (stat.div_done) begin
					cmd.d_upd = 1'b1;
					state_d   = ST_STORE;
				end
			end
			ST_STORE: begin
				case (phase_q)
					PH_A: begin
						cmd.store_a = 1'b1;
						phase_d     = PH_B;
						state_d     = ST_LOAD;
					end
					PH_B: begin
						cmd.store_b = 1'b1;
						state_d     = ST_MUL1;
					end
					default: state_d = ST_OUT;
				endcase
			end
			ST_MUL1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_P1;
				state_d     = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_P2;
				state_d     = ST_MUL3;
			end
			ST_MUL3: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MS_P3;
				state_d     = ST_COMB;
			end
			ST_COMB: begin
				cmd.combine = 1'b1;
				phase_d     = PH_R;
				state_d     = ST_EU_CHK;
			end
			ST_OUT: begin
				if (!stat.out_busy) begin
					cmd.out_write = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* hw/rtl/rational_arith_unit.sv */
`timescale 1ns / 1ps

// Exact fraction arithmetic: res = a op b, reduced, op = add/sub/mul/div by mode.
// Input channel: in_valid/in_stall with mode, a_num, a_den, b_num, b_den. One word
//   is taken at a time; in_stall is high from the cycle after acceptance until the
//   result has been placed in the output register.
// Output channel: out_valid/out_stall with res_num, res_den, div_zero, den_fixed.
//   The result sits in an output register; a new input word is accepted while it
//   waits. If the receiver still stalls when the next result is ready, the
//   controller holds that result internally until the output register frees up.
// Schedule: three reductions run in turn on one shared radix-2 divider. Each Euclid
//   remainder step is one division; the two operand reductions use the short
//   16-bit divide and the result reduction the full 32-bit one. Each reduction
//   ends with two exact divisions of numerator and denominator by the gcd, and an
//   operand reduction is then stored back. Each operand reduction follows an operand
//   load; the three products and the combine come before the result reduction. The
//   divider sets the rate: the next word is taken the cycle after the result is
//   registered.
// Reset (arst_n low) empties the pipeline: out_valid drops and the unit goes idle.

module rational_arith_unit import rau_pkg::*; (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      mode,
	input  logic signed [OPERAND_WIDTH-1:0] a_num,
	input  logic signed [OPERAND_WIDTH-1:0] a_den,
	input  logic signed [OPERAND_WIDTH-1:0] b_num,
	input  logic signed [OPERAND_WIDTH-1:0] b_den,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [NUM_W-1:0]         res_num,
	output logic signed [DEN_W-1:0]         res_den,
	output logic                            div_zero,
	output logic                            den_fixed
);

	cmd_t  cmd;
	stat_t stat;

	rau_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	rau_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.mode      (mode),
		.a_num     (a_num),
		.a_den     (a_den),
		.b_num     (b_num),
		.b_den     (b_den),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.res_num   (res_num),
		.res_den   (res_den),
		.div_zero  (div_zero),
		.den_fixed (den_fixed)
	);

endmodule
